[design/book_update_sequence_checker_assert.svh]
// Assertion macros shared by the checker of the book update sequence checker.
// Depends on nothing; the including file supplies clock, reset and properties.
`ifndef BOOK_UPDATE_SEQUENCE_CHECKER_ASSERT_SVH
`define BOOK_UPDATE_SEQUENCE_CHECKER_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define BUSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define BUSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/busc_pkg.sv]
// Shared types, codes and helpers for the book update sequence checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package busc_pkg;

   localparam int unsigned ID_BITS            = 63;
   localparam int unsigned SID_BITS           = 64;
   localparam int unsigned CNT_BITS_DEFAULT   = 32;
   localparam int unsigned COUNT_OUT_BITS     = 32;
   localparam int unsigned NUM_COUNTERS       = 6;
   localparam int unsigned MODE_BITS          = 2;
   localparam int unsigned DEC_BITS           = 3;
   localparam int unsigned PHASE_OUT_BITS     = 2;
   localparam int unsigned REQ_DATA_BITS      = 128;
   localparam int unsigned RSP_DATA_BITS      = 200;

   // Counter slots.
   localparam int unsigned CNT_SNAP  = 0;
   localparam int unsigned CNT_BUF   = 1;
   localparam int unsigned CNT_DISC  = 2;
   localparam int unsigned CNT_STALE = 3;
   localparam int unsigned CNT_APPLY = 4;
   localparam int unsigned CNT_GAP   = 5;

   // Phase as reported on the result channel.
   localparam logic [PHASE_OUT_BITS-1:0] PHASE_CODE_AWAIT  = 2'd0;
   localparam logic [PHASE_OUT_BITS-1:0] PHASE_CODE_LIVE   = 2'd1;
   localparam logic [PHASE_OUT_BITS-1:0] PHASE_CODE_RESYNC = 2'd2;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_UPDATE   = 2'd0,
      MODE_SNAPSHOT = 2'd1,
      MODE_RESYNC   = 2'd2
   } mode_type;

   typedef enum logic [DEC_BITS-1:0] {
      DEC_APPLY   = 3'd0,
      DEC_DISCARD = 3'd1,
      DEC_BUFFER  = 3'd2,
      DEC_GAP     = 3'd3,
      DEC_NONE    = 3'd4
   } decision_type;

   typedef enum logic [2:0] {
      PH_AWAIT  = 3'b001,
      PH_LIVE   = 3'b010,
      PH_RESYNC = 3'b100
   } phase_type;

   typedef struct packed {
      phase_type                   phase;
      logic                        first_pending;
      logic signed [SID_BITS-1:0]  snap_id;
      logic signed [SID_BITS-1:0]  applied_id;
   } seq_state_type;

   typedef struct packed {
      decision_type               decision;
      seq_state_type              next;
      logic [NUM_COUNTERS-1:0]    bump;
   } step_type;

   function automatic logic [PHASE_OUT_BITS-1:0] phase_code(input phase_type ph);
      logic [PHASE_OUT_BITS-1:0] code;
      unique case (ph)
         PH_AWAIT:  code = PHASE_CODE_AWAIT;
         PH_LIVE:   code = PHASE_CODE_LIVE;
         PH_RESYNC: code = PHASE_CODE_RESYNC;
         default:   code = PHASE_CODE_AWAIT;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[design/busc_decide.sv]
// Per-event decision logic: classifies one event against the sequence state.
// Depends on busc_pkg; purely combinational, used by the top level.
`timescale 1ns / 1ps
`default_nettype none

module busc_decide
   import busc_pkg::*;
(
   input  wire logic [MODE_BITS-1:0] mode,
   input  wire logic [ID_BITS-1:0]   start_id,
   input  wire logic [ID_BITS-1:0]   last_id,
   input  wire seq_state_type        cur,
   output step_type                  step
);

   logic signed [SID_BITS-1:0] first_s;
   logic signed [SID_BITS-1:0] last_s;
   logic signed [SID_BITS-1:0] first_m1;

   assign first_s  = $signed({1'b0, start_id});
   assign last_s   = $signed({1'b0, last_id});
   // Comparing first - 1 avoids any overflow on the stored id plus one.
   assign first_m1 = first_s - 64'sd1;

   always_comb begin
      step          = '0;
      step.decision = DEC_NONE;
      step.next     = cur;
      unique case (mode)
         MODE_UPDATE: begin
            if (cur.phase != PH_LIVE) begin
               step.decision      = DEC_BUFFER;
               step.bump[CNT_BUF] = 1'b1;
            end else if (cur.first_pending) begin
               if (last_s <= cur.snap_id) begin
                  step.decision       = DEC_DISCARD;
                  step.bump[CNT_DISC] = 1'b1;
               end else if (first_m1 > cur.snap_id) begin
                  // The snapshot is older than the first event can join.
                  step.decision        = DEC_GAP;
                  step.bump[CNT_STALE] = 1'b1;
                  step.next.phase      = PH_RESYNC;
               end else begin
                  step.decision            = DEC_APPLY;
                  step.bump[CNT_APPLY]     = 1'b1;
                  step.next.first_pending  = 1'b0;
                  step.next.applied_id     = last_s;
               end
            end else if (first_m1 == cur.applied_id) begin
               step.decision        = DEC_APPLY;
               step.bump[CNT_APPLY] = 1'b1;
               step.next.applied_id = last_s;
            end else if (last_s <= cur.applied_id) begin
               step.decision       = DEC_DISCARD;
               step.bump[CNT_DISC] = 1'b1;
            end else begin
               step.decision      = DEC_GAP;
               step.bump[CNT_GAP] = 1'b1;
               step.next.phase    = PH_RESYNC;
            end
         end
         MODE_SNAPSHOT: begin
            step.bump[CNT_SNAP]     = 1'b1;
            step.next.snap_id       = last_s;
            step.next.applied_id    = last_s;
            step.next.first_pending = 1'b1;
            step.next.phase         = PH_LIVE;
         end
         MODE_RESYNC: begin
            step.next.phase         = PH_AWAIT;
            step.next.first_pending = 1'b0;
            step.next.snap_id       = -64'sd1;
            step.next.applied_id    = -64'sd1;
         end
         default: begin
            step.decision = DEC_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/book_update_sequence_checker.sv]
// Book update sequence checker: one input register, one decision stage and a
// result register that also holds the sequence state and the event counters.
// One event is accepted per clock while the result channel is not stalled; its
// result passes through the input register and then the result register.
// The single decision stage compares the 63-bit update ids, widened to signed
// 64 bits, against the stored snapshot and last applied ids. Each
// result carries the decision, the phase after the event and the six
// saturating counters after the event. After reset the block awaits a snapshot.
`timescale 1ns / 1ps
`default_nettype none

module book_update_sequence_checker
   import busc_pkg::*;
#(
   parameter int unsigned COUNTER_BITS = CNT_BITS_DEFAULT
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // start_id[62:0], last_id[125:63], zero fill
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // mode[1:0]
   input  wire logic [MODE_BITS-1:0]     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // phase_now[1:0], count_snapshots[33:2], count_buffered[65:34],
   // count_discarded[97:66], count_stale[129:98], count_applied[161:130],
   // count_gaps[193:162], zero fill
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // decision[2:0]
   output logic [DEC_BITS-1:0]           rsp_tuser
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic [MODE_BITS-1:0]     in_mode_ff;
   logic [ID_BITS-1:0]       in_first_ff;
   logic [ID_BITS-1:0]       in_last_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   decision_type             rsp_decision_ff;
   seq_state_type            state_ff;
   logic                     advance;
   logic                     req_xfer;
   step_type                 step;

   logic [COUNTER_BITS-1:0]  cnt_ff  [NUM_COUNTERS];
   logic [COUNT_OUT_BITS-1:0] cnt_out [NUM_COUNTERS];

   // The decision stage moves when the result register is free or drains now.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   busc_decide u_decide (
      .mode     (in_mode_ff),
      .start_id (in_first_ff),
      .last_id  (in_last_ff),
      .cur      (state_ff),
      .step     (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_mode_ff  <= req_tuser;
         in_first_ff <= req_tdata[ID_BITS-1:0];
         in_last_ff  <= req_tdata[2*ID_BITS-1:ID_BITS];
      end
      if (advance) begin
         rsp_decision_ff <= step.decision;
      end
   end

   // State and counters change only with the result register, so they always
   // describe the result currently offered.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= PH_AWAIT;
         state_ff.first_pending <= 1'b0;
         state_ff.snap_id       <= -64'sd1;
         state_ff.applied_id    <= -64'sd1;
      end else if (advance) begin
         state_ff <= step.next;
      end
   end

   for (genvar g = 0; g < NUM_COUNTERS; g++) begin : g_cnt
      logic [COUNTER_BITS+COUNT_OUT_BITS-1:0] wide;

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[g] <= '0;
         end else if (advance && step.bump[g] && (cnt_ff[g] != '1)) begin
            cnt_ff[g] <= cnt_ff[g] + 1'b1;
         end
      end

      assign wide       = {{COUNT_OUT_BITS{1'b0}}, cnt_ff[g]};
      assign cnt_out[g] = wide[COUNT_OUT_BITS-1:0];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_decision_ff;
   assign rsp_tdata  = {6'b0,
                        cnt_out[CNT_GAP], cnt_out[CNT_APPLY], cnt_out[CNT_STALE],
                        cnt_out[CNT_DISC], cnt_out[CNT_BUF], cnt_out[CNT_SNAP],
                        phase_code(state_ff.phase)};

endmodule

`default_nettype wire

[design/busc_checker.sv]
// Port-level checker for the book update sequence checker, bound to the top.
// Depends on busc_pkg and book_update_sequence_checker_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "book_update_sequence_checker_assert.svh"

module busc_checker
   import busc_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input wire logic [MODE_BITS-1:0]     req_tuser,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic [DEC_BITS-1:0]      rsp_tuser
);

   // A stalled result transfer keeps its contents.
   `BUSC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // Buffering only happens outside the live phase.
   `BUSC_ASSERT(a_buffer_not_live, clock, reset, rsp_tvalid && (rsp_tuser == DEC_BUFFER) |-> rsp_tdata[1:0] != PHASE_CODE_LIVE, "buffered event while live")

   // Every gap forces a resync.
   `BUSC_ASSERT(a_gap_resync, clock, reset, rsp_tvalid && (rsp_tuser == DEC_GAP) |-> rsp_tdata[1:0] == PHASE_CODE_RESYNC, "gap without resync")

   // Applied or discarded events leave the book live.
   `BUSC_ASSERT(a_apply_live, clock, reset, rsp_tvalid && ((rsp_tuser == DEC_APPLY) || (rsp_tuser == DEC_DISCARD)) |-> rsp_tdata[1:0] == PHASE_CODE_LIVE, "apply or discard outside live phase")

   `BUSC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind book_update_sequence_checker busc_checker u_busc_checker (.*);

`default_nettype wire
